>>> rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the md5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int WORD_W    = 32;
    localparam int BUF_DEPTH = 16;
    localparam int LEN_BITS  = 32;   // width of the running bit count, 32..64

    typedef logic [LEN_BITS-1:0] t_bit_len;

    localparam logic [31:0] INIT_A   = 32'h67452301;
    localparam logic [31:0] INIT_B   = 32'hefcdab89;
    localparam logic [31:0] INIT_C   = 32'h98badcfe;
    localparam logic [31:0] INIT_D   = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_a;
        logic [31:0] digest_b;
        logic [31:0] digest_c;
        logic [31:0] digest_d;
    } t_out_beat;

    // message word used by a given round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] q;
        logic [3:0] q2x;
        logic [3:0] q4x;
        logic [3:0] q8x;
        logic [3:0] g;
        q   = rnd[3:0];
        q2x = {q[2:0], 1'b0};
        q4x = {q[1:0], 2'b00};
        q8x = {q[0], 3'b000};
        case (rnd[5:4])
            2'd0:    g = q;
            2'd1:    g = q4x + q + 4'd1;
            2'd2:    g = q2x + q + 4'd5;
            default: g = q8x - q;
        endcase
        return g;
    endfunction

    // rotate amount of a round
    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'd0:    s = 5'd7;
            4'd1:    s = 5'd12;
            4'd2:    s = 5'd17;
            4'd3:    s = 5'd22;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd9;
            4'd6:    s = 5'd14;
            4'd7:    s = 5'd20;
            4'd8:    s = 5'd4;
            4'd9:    s = 5'd11;
            4'd10:   s = 5'd16;
            4'd11:   s = 5'd23;
            4'd12:   s = 5'd6;
            4'd13:   s = 5'd10;
            4'd14:   s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    // sine-derived additive constant of a round
    function automatic logic [31:0] round_const(input logic [5:0] rnd);
        logic [31:0] k;
        case (rnd)
            6'd0:    k = 32'hd76aa478;
            6'd1:    k = 32'he8c7b756;
            6'd2:    k = 32'h242070db;
            6'd3:    k = 32'hc1bdceee;
            6'd4:    k = 32'hf57c0faf;
            6'd5:    k = 32'h4787c62a;
            6'd6:    k = 32'ha8304613;
            6'd7:    k = 32'hfd469501;
            6'd8:    k = 32'h698098d8;
            6'd9:    k = 32'h8b44f7af;
            6'd10:   k = 32'hffff5bb1;
            6'd11:   k = 32'h895cd7be;
            6'd12:   k = 32'h6b901122;
            6'd13:   k = 32'hfd987193;
            6'd14:   k = 32'ha679438e;
            6'd15:   k = 32'h49b40821;
            6'd16:   k = 32'hf61e2562;
            6'd17:   k = 32'hc040b340;
            6'd18:   k = 32'h265e5a51;
            6'd19:   k = 32'he9b6c7aa;
            6'd20:   k = 32'hd62f105d;
            6'd21:   k = 32'h02441453;
            6'd22:   k = 32'hd8a1e681;
            6'd23:   k = 32'he7d3fbc8;
            6'd24:   k = 32'h21e1cde6;
            6'd25:   k = 32'hc33707d6;
            6'd26:   k = 32'hf4d50d87;
            6'd27:   k = 32'h455a14ed;
            6'd28:   k = 32'ha9e3e905;
            6'd29:   k = 32'hfcefa3f8;
            6'd30:   k = 32'h676f02d9;
            6'd31:   k = 32'h8d2a4c8a;
            6'd32:   k = 32'hfffa3942;
            6'd33:   k = 32'h8771f681;
            6'd34:   k = 32'h6d9d6122;
            6'd35:   k = 32'hfde5380c;
            6'd36:   k = 32'ha4beea44;
            6'd37:   k = 32'h4bdecfa9;
            6'd38:   k = 32'hf6bb4b60;
            6'd39:   k = 32'hbebfbc70;
            6'd40:   k = 32'h289b7ec6;
            6'd41:   k = 32'heaa127fa;
            6'd42:   k = 32'hd4ef3085;
            6'd43:   k = 32'h04881d05;
            6'd44:   k = 32'hd9d4d039;
            6'd45:   k = 32'he6db99e5;
            6'd46:   k = 32'h1fa27cf8;
            6'd47:   k = 32'hc4ac5665;
            6'd48:   k = 32'hf4292244;
            6'd49:   k = 32'h432aff97;
            6'd50:   k = 32'hab9423a7;
            6'd51:   k = 32'hfc93a039;
            6'd52:   k = 32'h655b59c3;
            6'd53:   k = 32'h8f0ccc92;
            6'd54:   k = 32'hffeff47d;
            6'd55:   k = 32'h85845dd1;
            6'd56:   k = 32'h6fa87e4f;
            6'd57:   k = 32'hfe2ce6e0;
            6'd58:   k = 32'ha3014314;
            6'd59:   k = 32'h4e0811a1;
            6'd60:   k = 32'hf7537e82;
            6'd61:   k = 32'hbd3af235;
            6'd62:   k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/md5_ram.sv
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/md5_message_digest_top.sv
// ----------------------------------------------------------------------------
// md5_message_digest_top
// MD5 digest of a message streamed as 32-bit little-endian words.
// ----------------------------------------------------------------------------
// Input channel: one message word per beat, first byte in bits 7..0. Only a
// beat with last set may carry fewer than four bytes; a last beat with zero
// bytes closes the message (alone it gives the digest of the empty message).
// Output channel: one beat per message holding the four chaining words.
// Each accepted word is written into a 16-word block RAM. When the block
// fills, input stalls while the round registers are loaded, the 64 rounds
// run at one per cycle (each round reads its message word from the RAM
// ahead of it), and the result is folded into the chaining words. After
// the last beat the padding and length words are written one per cycle,
// followed by one or two compressions.
// Input is taken while a digest waits in the output register; only the
// next digest waits for the receiver. Reset restores the initial chaining
// words and clears the word and bit counts; the RAM is not cleared.
// ----------------------------------------------------------------------------
module md5_message_digest_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  md5_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output md5_pkg::t_out_beat o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [3:0]          r_fill;
    md5_pkg::t_bit_len   r_bit_len;
    logic [5:0]          r_round;
    logic [31:0]         r_k;
    logic [31:0]         r_ca, r_cb, r_cc, r_cd;
    logic [31:0]         r_wa, r_wb, r_wc, r_wd;
    logic                r_need80;
    logic                r_low_done;
    logic                r_len_done;
    logic                r_finish;
    logic                r_out_valid;
    md5_pkg::t_out_beat  r_out_data;

    logic                accept;
    logic [2:0]          cnt;
    logic [31:0]         in_word;
    logic [31:0]         pad_word;
    logic [63:0]         len_ext;
    md5_pkg::t_bit_len   len_add;
    logic                ram_wr_en;
    logic [31:0]         ram_wr_data;
    logic                ram_rd_en;
    logic [3:0]          ram_rd_addr;
    logic [31:0]         ram_rd_data;
    logic [5:0]          n_round;
    logic [31:0]         f_val;
    logic [31:0]         sum;
    logic [63:0]         rot_dbl;
    logic [31:0]         n_wb;
    logic                out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign out_free    = !r_out_valid || i_out_ready;

    // bytes taken from this beat
    always_comb begin
        if (!i_in_data.last || i_in_data.byte_count > 3'd4) begin
            cnt = 3'd4;
        end else begin
            cnt = i_in_data.byte_count;
        end
    end

    // word written for the accepted beat, with the pad byte where it fits
    always_comb begin
        case (cnt)
            3'd0:    in_word = {24'h0, md5_pkg::PAD_BYTE};
            3'd1:    in_word = {16'h0, md5_pkg::PAD_BYTE, i_in_data.data_word[7:0]};
            3'd2:    in_word = {8'h0, md5_pkg::PAD_BYTE, i_in_data.data_word[15:0]};
            3'd3:    in_word = {md5_pkg::PAD_BYTE, i_in_data.data_word[23:0]};
            default: in_word = i_in_data.data_word;
        endcase
    end

    assign len_add = md5_pkg::t_bit_len'({cnt, 3'b000});
    assign len_ext = 64'(r_bit_len);

    always_comb begin
        if (r_need80) begin
            pad_word = {24'h0, md5_pkg::PAD_BYTE};
        end else if (!r_low_done) begin
            pad_word = (r_fill == 4'd14) ? len_ext[31:0] : 32'h0;
        end else begin
            pad_word = len_ext[63:32];
        end
    end

    assign ram_wr_en   = accept || (r_state == S_PAD);
    assign ram_wr_data = accept ? in_word : pad_word;

    // message word for the next round is fetched during the current round
    assign n_round     = r_round + 6'd1;
    assign ram_rd_en   = (r_state == S_LOAD) || (r_state == S_ROUND);
    assign ram_rd_addr = (r_state == S_LOAD) ? md5_pkg::msg_index(6'd0)
                                             : md5_pkg::msg_index(n_round);

    md5_ram #(
        .WIDTH (md5_pkg::WORD_W),
        .DEPTH (md5_pkg::BUF_DEPTH)
    ) u_block_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // one md5 round
    always_comb begin
        case (r_round[5:4])
            2'd0:    f_val = (r_wb & r_wc) | (~r_wb & r_wd);
            2'd1:    f_val = (r_wd & r_wb) | (~r_wd & r_wc);
            2'd2:    f_val = r_wb ^ r_wc ^ r_wd;
            default: f_val = r_wc ^ (r_wb | ~r_wd);
        endcase
        sum     = r_wa + f_val + r_k + ram_rd_data;
        rot_dbl = {sum, sum} << md5_pkg::rot_amount(r_round);
        n_wb    = r_wb + rot_dbl[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_bit_len   <= '0;
            r_round     <= '0;
            r_ca        <= md5_pkg::INIT_A;
            r_cb        <= md5_pkg::INIT_B;
            r_cc        <= md5_pkg::INIT_C;
            r_cd        <= md5_pkg::INIT_D;
            r_need80    <= 1'b0;
            r_low_done  <= 1'b0;
            r_len_done  <= 1'b0;
            r_finish    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fill     <= r_fill + 4'd1;
                        r_bit_len  <= r_bit_len + len_add;
                        r_finish   <= i_in_data.last;
                        r_need80   <= i_in_data.last && (cnt == 3'd4);
                        r_low_done <= 1'b0;
                        r_len_done <= 1'b0;
                        if (r_fill == 4'd15) begin
                            r_state <= S_LOAD;
                        end else if (i_in_data.last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_fill <= r_fill + 4'd1;
                    if (r_need80) begin
                        r_need80 <= 1'b0;
                    end else if (!r_low_done) begin
                        if (r_fill == 4'd14) begin
                            r_low_done <= 1'b1;
                        end
                    end else begin
                        r_len_done <= 1'b1;
                    end
                    if (r_fill == 4'd15) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_wa    <= r_ca;
                    r_wb    <= r_cb;
                    r_wc    <= r_cc;
                    r_wd    <= r_cd;
                    r_round <= '0;
                    r_k     <= md5_pkg::round_const(6'd0);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_wa    <= r_wd;
                    r_wd    <= r_wc;
                    r_wc    <= r_wb;
                    r_wb    <= n_wb;
                    r_round <= n_round;
                    r_k     <= md5_pkg::round_const(n_round);
                    if (r_round == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_ca <= r_ca + r_wa;
                    r_cb <= r_cb + r_wb;
                    r_cc <= r_cc + r_wc;
                    r_cd <= r_cd + r_wd;
                    if (r_len_done) begin
                        r_state <= S_OUT;
                    end else if (r_finish) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_data  <= '{digest_a: r_ca, digest_b: r_cb,
                                         digest_c: r_cc, digest_d: r_cd};
                        r_ca        <= md5_pkg::INIT_A;
                        r_cb        <= md5_pkg::INIT_B;
                        r_cc        <= md5_pkg::INIT_C;
                        r_cd        <= md5_pkg::INIT_D;
                        r_fill      <= '0;
                        r_bit_len   <= '0;
                        r_finish    <= 1'b0;
                        r_len_done  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // no block ram write while a compression is reading it
    a_no_write_in_compress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_ROUND) |-> !ram_wr_en)
        else $error("block ram written during compression");

    // a compression starts only on a full block
    a_load_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_fill == 4'd0))
        else $error("compression started on a partial block");

    // round counter rests at zero outside the round loop
    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND) |-> (r_round == 6'd0))
        else $error("round counter not at zero");

    // fold happens only right after round 63
    a_add_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == 6'd63) |=> (r_state == S_ADD))
        else $error("fold not after last round");

    // digest hand-off leaves a fresh message context
    a_digest_resets_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=>
            (o_out_valid && r_fill == 4'd0 && r_bit_len == '0 && r_state == S_IDLE))
        else $error("message context not cleared after digest");

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the md5 message digest block: random messages of
// mixed lengths and tail sizes are streamed in, each digest is predicted by a
// behavioral md5 model and compared word by word with the block's output.
// ----------------------------------------------------------------------------
module tb;

    // rotate amounts, four per round group
    localparam logic [0:15][4:0] MD5_ROT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };
    localparam int HOLD_CYCLES = 1000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    md5_pkg::t_in_beat  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    md5_pkg::t_out_beat o_out_data;

    // model state
    logic [31:0]       md5_chain [4];
    logic [31:0]       msg_block [16];
    int unsigned       msg_fill;
    md5_pkg::t_bit_len msg_bits;

    md5_pkg::t_in_beat  beat_backlog [$];
    md5_pkg::t_out_beat pending_digests [$];

    logic        burst_mode    = 1'b0;
    logic        rx_hold_req   = 1'b0;
    logic        rx_hold_taken = 1'b0;
    int unsigned rx_hold_left  = 0;

    int unsigned n_queued  = 0;
    int unsigned n_msgs    = 0;
    int unsigned n_beats   = 0;
    int unsigned n_blocks  = 0;
    int unsigned n_checked = 0;
    int unsigned n_held    = 0;
    int unsigned n_errors  = 0;

    md5_message_digest_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic md5_new_message();
        md5_chain[0] = md5_pkg::INIT_A;
        md5_chain[1] = md5_pkg::INIT_B;
        md5_chain[2] = md5_pkg::INIT_C;
        md5_chain[3] = md5_pkg::INIT_D;
        msg_fill     = 0;
        msg_bits     = '0;
    endtask

    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, k, sum, rot;
        int          grp, q, g, s;
        real         sn;
        a = md5_chain[0];
        b = md5_chain[1];
        c = md5_chain[2];
        d = md5_chain[3];
        for (int r = 0; r < 64; r++) begin
            grp = r / 16;
            q   = r % 16;
            case (grp)
                0: begin
                    f = (b & c) | (~b & d);
                    g = q;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * q + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * q + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * q) % 16;
                end
            endcase
            // round constant: floor(|sin(r+1)| * 2^32)
            sn = $sin(real'(r + 1));
            if (sn < 0.0) sn = -sn;
            k   = 32'(longint'($floor(sn * 4294967296.0)));
            sum = a + f + k + msg_block[g];
            s   = MD5_ROT[grp * 4 + q % 4];
            rot = (sum << s) | (sum >> (32 - s));
            a   = d;
            d   = c;
            c   = b;
            b   = b + rot;
        end
        md5_chain[0] += a;
        md5_chain[1] += b;
        md5_chain[2] += c;
        md5_chain[3] += d;
        n_blocks++;
    endtask

    task automatic md5_push(input logic [31:0] w);
        msg_block[msg_fill] = w;
        msg_fill = (msg_fill + 1) % 16;
        if (msg_fill == 0) md5_compress();
    endtask

    task automatic md5_absorb(input md5_pkg::t_in_beat beat);
        int unsigned nbytes;
        logic [31:0] keep;
        logic [63:0] len;
        if (!beat.last) begin
            // short counts on inner words are ignored
            msg_bits = msg_bits + md5_pkg::t_bit_len'(32);
            md5_push(beat.data_word);
        end else begin
            nbytes   = (beat.byte_count > 3'd4) ? 4 : beat.byte_count;
            msg_bits = msg_bits + md5_pkg::t_bit_len'(8 * nbytes);
            if (nbytes == 4) begin
                md5_push(beat.data_word);
                md5_push({24'h0, md5_pkg::PAD_BYTE});
            end else begin
                keep = (nbytes == 0) ? 32'h0 : 32'hffffffff >> (32 - 8 * nbytes);
                md5_push((beat.data_word & keep) |
                         ({24'h0, md5_pkg::PAD_BYTE} << (8 * nbytes)));
            end
            while (msg_fill != 14) md5_push(32'h0);
            len = 64'(msg_bits);
            md5_push(len[31:0]);
            md5_push(len[63:32]);
            pending_digests.push_back(md5_pkg::t_out_beat'{md5_chain[0], md5_chain[1],
                                                           md5_chain[2], md5_chain[3]});
            md5_new_message();
        end
    endtask

    task automatic check_digest(input md5_pkg::t_out_beat got);
        md5_pkg::t_out_beat want;
        if (pending_digests.size() == 0) begin
            $error("unexpected digest beat %h", got);
            n_errors++;
        end else begin
            want = pending_digests.pop_front();
            n_checked++;
            if (got.digest_a !== want.digest_a) begin
                $error("digest_a: expected %h, actual %h", want.digest_a, got.digest_a);
                n_errors++;
            end
            if (got.digest_b !== want.digest_b) begin
                $error("digest_b: expected %h, actual %h", want.digest_b, got.digest_b);
                n_errors++;
            end
            if (got.digest_c !== want.digest_c) begin
                $error("digest_c: expected %h, actual %h", want.digest_c, got.digest_c);
                n_errors++;
            end
            if (got.digest_d !== want.digest_d) begin
                $error("digest_d: expected %h, actual %h", want.digest_d, got.digest_d);
                n_errors++;
            end
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_beat(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
        md5_pkg::t_in_beat b;
        b.data_word  = w;
        b.byte_count = cnt;
        b.last       = lst;
        beat_backlog.push_back(b);
        n_queued++;
        if (lst) n_msgs++;
    endtask

    task automatic queue_message(input int unsigned n_words, input logic [2:0] last_cnt);
        for (int i = 0; i < n_words; i++)
            queue_beat(rand_word(), 3'($urandom_range(0, 7)), 1'b0);
        queue_beat(rand_word(), last_cnt, 1'b1);
    endtask

    task automatic queue_random_message();
        int unsigned n_words;
        // mostly under one block so padding spill cases come up often
        if ($urandom_range(0, 9) < 8) n_words = $urandom_range(0, 15);
        else n_words = $urandom_range(16, 40);
        queue_message(n_words, 3'($urandom_range(0, 7)));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (beat_backlog.size() != 0 || i_in_valid || pending_digests.size() != 0);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (beat_backlog.size() != 0 && (burst_mode || $urandom_range(0, 99) >= 31)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= beat_backlog.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready  <= 1'b0;
            rx_hold_left <= 0;
        end else if (rx_hold_req && !rx_hold_taken) begin
            rx_hold_taken <= 1'b1;
            rx_hold_left  <= HOLD_CYCLES;
            i_out_ready   <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= burst_mode || ($urandom_range(0, 99) >= 31);
        end
    end

    // monitor: predict on accepted words, check on accepted digests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                md5_absorb(i_in_data);
                n_beats++;
            end
            if (i_in_valid && !o_in_ready && rx_hold_left != 0) n_held++;
            if (o_out_valid && i_out_ready) check_digest(o_out_data);
        end
    end

    initial begin
        md5_new_message();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty message, every tail size, short inner words, data extremes
        queue_beat(32'h0, 3'd0, 1'b1);
        queue_beat(32'hffffffff, 3'd1, 1'b1);
        queue_beat(32'hffffffff, 3'd2, 1'b1);
        queue_beat(32'h0, 3'd3, 1'b1);
        queue_beat(32'hffffffff, 3'd4, 1'b1);
        queue_beat($urandom, 3'd5, 1'b1);
        queue_beat($urandom, 3'd6, 1'b1);
        queue_beat(32'hffffffff, 3'd7, 1'b1);
        queue_beat(32'hffffffff, 3'd1, 1'b0);
        queue_beat(32'h0, 3'd0, 1'b0);
        queue_beat($urandom, 3'd6, 1'b1);
        // tail lands on slot 13, length fits without a spill block
        queue_message(13, 3'd3);
        wait_drained();

        while (n_queued < 170) queue_random_message();

        burst_mode = 1'b1;
        repeat (6) queue_random_message();
        wait_drained();
        burst_mode = 1'b0;

        // hold the digest port while short messages keep coming
        rx_hold_req = 1'b1;
        repeat (10) queue_message($urandom_range(0, 1), 3'($urandom_range(0, 7)));
        do @(negedge i_clk);
        while (!rx_hold_taken || rx_hold_left != 0);
        wait_drained();

        while (n_queued < 400 || n_msgs < 45) queue_random_message();
        wait_drained();
        repeat (400) @(negedge i_clk);

        $display("run: %0d words in %0d messages, %0d blocks hashed, %0d digests checked",
                 n_beats, n_msgs, n_blocks, n_checked);
        $display("run: input held back for %0d cycles while the digest port was blocked",
                 n_held);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
